// ===== rtl/fac_pkg.sv =====
// Shared types, constants and the arctangent table for the full-circle arctangent.
`timescale 1ns / 1ps
package fac_pkg;

    localparam int DATA_WIDTH_DEF  = 16;
    localparam int ANGLE_WIDTH_DEF = 16;

    // Phase is a 32-bit unsigned fraction of a turn, wrapping modulo one turn.
    localparam int TURN_BITS    = 32;
    localparam int CORDIC_STEPS = 32;

    // Vector datapath width: normalized magnitude stays below 2^32 and the
    // CORDIC gain with the diagonal stays below 2^34; one spare bit on top.
    localparam int VEC_W = 36;

    localparam logic [TURN_BITS-1:0] HALF_TURN = {1'b1, {(TURN_BITS-1){1'b0}}};

    // Quarter-turn code for the axis cases.
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } fac_quad_t;

    typedef struct packed {
        logic      valid;
        logic      special;
        fac_quad_t quad;
    } fac_ctl_t;

    typedef logic signed [VEC_W-1:0] fac_vec_t;
    typedef logic [TURN_BITS-1:0]    fac_turn_t;

    // round(atan(2^-i) / (2*pi) * 2^32)
    function automatic fac_turn_t atan_turn(input int unsigned idx);
        fac_turn_t r;
        begin
            unique case (idx)
                0:  r = 32'd536870912;
                1:  r = 32'd316933406;
                2:  r = 32'd167458907;
                3:  r = 32'd85004756;
                4:  r = 32'd42667331;
                5:  r = 32'd21354465;
                6:  r = 32'd10679838;
                7:  r = 32'd5340245;
                8:  r = 32'd2670163;
                9:  r = 32'd1335087;
                10: r = 32'd667544;
                11: r = 32'd333772;
                12: r = 32'd166886;
                13: r = 32'd83443;
                14: r = 32'd41722;
                15: r = 32'd20861;
                16: r = 32'd10430;
                17: r = 32'd5215;
                18: r = 32'd2608;
                19: r = 32'd1304;
                20: r = 32'd652;
                21: r = 32'd326;
                22: r = 32'd163;
                23: r = 32'd81;
                24: r = 32'd41;
                25: r = 32'd20;
                26: r = 32'd10;
                27: r = 32'd5;
                28: r = 32'd3;
                29: r = 32'd1;
                30: r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/fac_cordic_stage.sv =====
// One registered vectoring CORDIC micro-rotation.
`timescale 1ns / 1ps
module fac_cordic_stage
    import fac_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      ce,
    input  fac_ctl_t  ctl_in,
    input  fac_vec_t  x_in,
    input  fac_vec_t  y_in,
    input  fac_turn_t z_in,
    output fac_ctl_t  ctl_out,
    output fac_vec_t  x_out,
    output fac_vec_t  y_out,
    output fac_turn_t z_out
);

    localparam fac_turn_t ATAN_STEP = atan_turn(STEP);

    fac_ctl_t  ctl_reg;
    fac_vec_t  x_reg, x_next;
    fac_vec_t  y_reg, y_next;
    fac_turn_t z_reg, z_next;

    always_comb
    begin
        fac_vec_t xs;
        fac_vec_t ys;
        xs = x_in >>> STEP;
        ys = y_in >>> STEP;
        // rotate toward the axis: sign of y picks the direction
        if (!y_in[VEC_W-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN_STEP;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (ce)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

// ===== rtl/full_circle_arctangent.sv =====
// Top level of the pipelined full-circle arctangent (atan2 over [0, 2*pi)).
`timescale 1ns / 1ps
//
//  Channel  Handshake                    Payload                 Direction
//  -------  ---------------------------  ----------------------  ---------
//  vector   vector_valid / vector_stall  opposite, adjacent      in
//  angle    angle_valid  / angle_stall   angle                   out
//
//  An accepted vector reaches its angle on the output register through the
//  reflect, magnitude, two normalize, 32 CORDIC and rounding/output stages.
//  One transaction is taken every cycle in which the pipeline is not held.
//  Reset (rst_n, asynchronous) clears only the control bits of every stage.
//  The pipeline advances as a whole; it holds only when the output register
//  is full and stalled and the last CORDIC stage also carries a transaction,
//  so bubbles drain into a waiting output.
//
module full_circle_arctangent
    import fac_pkg::*;
#(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         vector_valid,
    output logic                         vector_stall,
    input  logic signed [DATA_WIDTH-1:0] opposite,
    input  logic signed [DATA_WIDTH-1:0] adjacent,
    output logic                         angle_valid,
    input  logic                         angle_stall,
    output logic [ANGLE_WIDTH-1:0]       angle
);

    // Rounding constant: half an output LSB in phase units.
    localparam int        HALF_POS  = (ANGLE_WIDTH < TURN_BITS) ?
                                      (TURN_BITS - 1 - ANGLE_WIDTH) : 0;
    localparam fac_turn_t ROUND_ADD = (ANGLE_WIDTH < TURN_BITS) ?
                                      (fac_turn_t'(1) << HALF_POS) : '0;

    logic ce;

    // ---------------- stage 1: axis cases and reflection ----------------
    fac_ctl_t  ctl1_reg, ctl1_next;
    fac_vec_t  x1_reg, x1_next;
    fac_vec_t  y1_reg, y1_next;
    fac_turn_t z1_reg, z1_next;

    always_comb
    begin
        fac_vec_t opp_ext;
        fac_vec_t adj_ext;
        logic     opp_zero;
        logic     adj_zero;
        logic     adj_neg;
        opp_ext  = fac_vec_t'(opposite);
        adj_ext  = fac_vec_t'(adjacent);
        opp_zero = (opposite == '0);
        adj_zero = (adjacent == '0);
        adj_neg  = adjacent[DATA_WIDTH-1];

        ctl1_next.valid   = vector_valid;
        ctl1_next.special = opp_zero || adj_zero;
        // opposite zero wins, so the origin lands on a half turn
        if (opp_zero)
        begin
            ctl1_next.quad = (!adj_neg && !adj_zero) ? QUAD_0 : QUAD_2;
        end
        else
        begin
            ctl1_next.quad = !opposite[DATA_WIDTH-1] ? QUAD_1 : QUAD_3;
        end

        // reflect into the right half-plane and book a half turn for it
        if (adj_neg)
        begin
            x1_next = -adj_ext;
            y1_next = -opp_ext;
            z1_next = HALF_TURN;
        end
        else
        begin
            x1_next = adj_ext;
            y1_next = opp_ext;
            z1_next = '0;
        end
    end

    // ---------------- stage 2: larger magnitude ----------------
    fac_ctl_t  ctl2_reg;
    fac_vec_t  x2_reg;
    fac_vec_t  y2_reg;
    fac_turn_t z2_reg;
    fac_turn_t m2_reg, m2_next;

    always_comb
    begin
        fac_vec_t  y_abs;
        fac_turn_t x_mag;
        fac_turn_t y_mag;
        y_abs   = y1_reg[VEC_W-1] ? -y1_reg : y1_reg;
        x_mag   = x1_reg[TURN_BITS-1:0];
        y_mag   = y_abs[TURN_BITS-1:0];
        m2_next = (y_mag > x_mag) ? y_mag : x_mag;
    end

    // ---------------- stage 3: normalize by 16 and 8 ----------------
    fac_ctl_t  ctl3_reg;
    fac_vec_t  x3_reg, x3_next;
    fac_vec_t  y3_reg, y3_next;
    fac_turn_t z3_reg;
    fac_turn_t m3_reg, m3_next;

    always_comb
    begin
        x3_next = x2_reg;
        y3_next = y2_reg;
        m3_next = m2_reg;
        if (m3_next[TURN_BITS-1 -: 16] == '0)
        begin
            x3_next = x3_next <<< 16;
            y3_next = y3_next <<< 16;
            m3_next = m3_next << 16;
        end
        if (m3_next[TURN_BITS-1 -: 8] == '0)
        begin
            x3_next = x3_next <<< 8;
            y3_next = y3_next <<< 8;
            m3_next = m3_next << 8;
        end
    end

    // ---------------- stage 4: normalize by 4, 2 and 1 ----------------
    fac_ctl_t  ctl4_reg;
    fac_vec_t  x4_reg, x4_next;
    fac_vec_t  y4_reg, y4_next;
    fac_turn_t z4_reg;
    fac_turn_t m4_reg, m4_next;

    always_comb
    begin
        x4_next = x3_reg;
        y4_next = y3_reg;
        m4_next = m3_reg;
        if (m4_next[TURN_BITS-1 -: 4] == '0)
        begin
            x4_next = x4_next <<< 4;
            y4_next = y4_next <<< 4;
            m4_next = m4_next << 4;
        end
        if (m4_next[TURN_BITS-1 -: 2] == '0)
        begin
            x4_next = x4_next <<< 2;
            y4_next = y4_next <<< 2;
            m4_next = m4_next << 2;
        end
        if (!m4_next[TURN_BITS-1])
        begin
            x4_next = x4_next <<< 1;
            y4_next = y4_next <<< 1;
            m4_next = m4_next << 1;
        end
    end

    // front-end registers: control words reset, payload free-running under ce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else if (ce)
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            z1_reg <= z1_next;
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
            z2_reg <= z1_reg;
            m2_reg <= m2_next;
            x3_reg <= x3_next;
            y3_reg <= y3_next;
            z3_reg <= z2_reg;
            m3_reg <= m3_next;
            x4_reg <= x4_next;
            y4_reg <= y4_next;
            z4_reg <= z3_reg;
            m4_reg <= m4_next;
        end
    end

    // ---------------- CORDIC micro-rotations ----------------
    fac_ctl_t  ctl_c [0:CORDIC_STEPS];
    fac_vec_t  x_c   [0:CORDIC_STEPS-1];
    fac_vec_t  y_c   [0:CORDIC_STEPS-1];
    fac_turn_t z_c   [0:CORDIC_STEPS];

    assign ctl_c[0] = ctl4_reg;
    assign x_c[0]   = x4_reg;
    assign y_c[0]   = y4_reg;
    assign z_c[0]   = z4_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_step
        if (g < CORDIC_STEPS - 1)
        begin : g_mid
            fac_cordic_stage #(
                .STEP (g)
            ) u_stage (
                .clk     (clk),
                .rst_n   (rst_n),
                .ce      (ce),
                .ctl_in  (ctl_c[g]),
                .x_in    (x_c[g]),
                .y_in    (y_c[g]),
                .z_in    (z_c[g]),
                .ctl_out (ctl_c[g+1]),
                .x_out   (x_c[g+1]),
                .y_out   (y_c[g+1]),
                .z_out   (z_c[g+1])
            );
        end
        else
        begin : g_last
            // only the phase leaves the final rotation
            fac_cordic_stage #(
                .STEP (g)
            ) u_stage (
                .clk     (clk),
                .rst_n   (rst_n),
                .ce      (ce),
                .ctl_in  (ctl_c[g]),
                .x_in    (x_c[g]),
                .y_in    (y_c[g]),
                .z_in    (z_c[g]),
                .ctl_out (ctl_c[g+1]),
                .x_out   (),
                .y_out   (),
                .z_out   (z_c[g+1])
            );
        end
    end

    // ---------------- rounding and output register ----------------
    fac_ctl_t               ctl_last;
    logic                   angle_valid_reg, angle_valid_next;
    logic [ANGLE_WIDTH-1:0] angle_reg, angle_next;

    assign ctl_last = ctl_c[CORDIC_STEPS];

    // Hold the whole pipe only when a full, stalled output would be overwritten.
    assign ce           = !(angle_valid_reg && angle_stall && ctl_last.valid);
    assign vector_stall = !ce;

    always_comb
    begin
        fac_turn_t z_sel;
        fac_turn_t z_round;
        // axis cases take an exact multiple of a quarter turn
        z_sel      = ctl_last.special ? {ctl_last.quad, {(TURN_BITS-2){1'b0}}}
                                      : z_c[CORDIC_STEPS];
        // round half up; the carry out of the top drops, so a full turn wraps
        z_round    = z_sel + ROUND_ADD;
        angle_next = z_round[TURN_BITS-1 -: ANGLE_WIDTH];

        priority if (ce && ctl_last.valid)
        begin
            angle_valid_next = 1'b1;
        end
        else if (!angle_stall)
        begin
            angle_valid_next = 1'b0;
        end
        else
        begin
            angle_valid_next = angle_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_valid_reg <= 1'b0;
        end
        else
        begin
            angle_valid_reg <= angle_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce && ctl_last.valid)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle_valid = angle_valid_reg;
    assign angle       = angle_reg;

    // ---------------- assertions ----------------
    // Reflection must leave a nonnegative adjacent component.
    a_reflect_right: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl1_reg.valid && !ctl1_reg.special) |-> !x1_reg[VEC_W-1])
        else $error("reflected adjacent component is negative");

    // Normalization must bring the larger magnitude up to the top phase bit.
    a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl4_reg.valid && !ctl4_reg.special) |-> m4_reg[TURN_BITS-1])
        else $error("vector not normalized before rotations");

    // A new result appears only when the last rotation stage carried one.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(angle_valid_reg) |-> $past(ctl_last.valid && ce))
        else $error("output valid without a transaction from the pipeline");

    // Axis cases deliver an exact multiple of a quarter turn.
    a_axis_quarter: assert property (@(posedge clk) disable iff (!rst_n)
        (ce && ctl_last.valid && ctl_last.special)
        |=> (angle_reg[ANGLE_WIDTH-3:0] == '0))
        else $error("axis case angle is not a whole quarter turn");

endmodule

// ===== tb/fac_angle_check.sv =====
// Channel monitor and scoreboard for the full-circle arctangent: predicts each angle and compares.
`timescale 1ns / 1ps
module fac_angle_check
    import fac_pkg::*;
#(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         vector_valid,
    input  logic                         vector_stall,
    input  logic signed [DATA_WIDTH-1:0] opposite,
    input  logic signed [DATA_WIDTH-1:0] adjacent,
    input  logic                         angle_valid,
    input  logic                         angle_stall,
    input  logic [ANGLE_WIDTH-1:0]       angle,
    output int                           fail_count,
    output int                           pending,
    output int                           vectors_seen,
    output int                           angles_seen,
    output int                           axis_seen
);

    localparam logic [TURN_BITS-1:0] QUARTER_TURN       = 32'h4000_0000;
    localparam logic [TURN_BITS-1:0] THREE_QUARTER_TURN = 32'hC000_0000;
    localparam longint               NORM_FLOOR         = 64'h0000_0000_8000_0000;
    localparam int                   PRINT_LIMIT        = 20;

    // atan(2^-i) as a 32-bit fraction of a turn, rounded to nearest
    localparam logic [TURN_BITS-1:0] TURN_STEP [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef struct {
        logic signed [DATA_WIDTH-1:0] opp;
        logic signed [DATA_WIDTH-1:0] adj;
        logic [ANGLE_WIDTH-1:0]       angle;
    } angle_case_t;

    angle_case_t angle_fifo [$];

    function automatic logic [ANGLE_WIDTH-1:0] angle_of(
        input logic signed [DATA_WIDTH-1:0] opp,
        input logic signed [DATA_WIDTH-1:0] adj
    );
        longint               y;
        longint               x;
        longint               xs;
        longint               ys;
        longint               mag;
        logic [TURN_BITS-1:0] z;
        logic [63:0]          r;
        int                   i;
        y = opp;
        x = adj;
        z = '0;
        if (y == 0)
        begin
            z = (x > 0) ? '0 : HALF_TURN;
        end
        else if (x == 0)
        begin
            z = (y > 0) ? QUARTER_TURN : THREE_QUARTER_TURN;
        end
        else
        begin
            // fold into the right half-plane, then scale up to full precision
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = HALF_TURN;
            end
            mag = (y < 0) ? -y : y;
            if (x > mag)
                mag = x;
            while (mag < NORM_FLOOR)
            begin
                x   = x * 2;
                y   = y * 2;
                mag = mag * 2;
            end
            for (i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + TURN_STEP[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - TURN_STEP[i];
                end
            end
        end
        if (ANGLE_WIDTH >= TURN_BITS)
            return ANGLE_WIDTH'(z);
        // round half up, drop the carry out of a full turn
        r = ({32'b0, z} + (64'd1 << (TURN_BITS - ANGLE_WIDTH - 1))) >> (TURN_BITS - ANGLE_WIDTH);
        return r[ANGLE_WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_LIMIT)
            $display("%0t ns: angle mismatch: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk)
    begin : watch
        angle_case_t c;
        if (rst_n)
        begin
            if (vector_valid && !vector_stall)
            begin
                c.opp   = opposite;
                c.adj   = adjacent;
                c.angle = angle_of(opposite, adjacent);
                angle_fifo.push_back(c);
                vectors_seen <= vectors_seen + 1;
                if (opposite == 0 || adjacent == 0)
                    axis_seen <= axis_seen + 1;
            end
            if (angle_valid && !angle_stall)
            begin
                angles_seen <= angles_seen + 1;
                if (angle_fifo.size() == 0)
                begin
                    report_mismatch($sformatf("angle %0d with no vector outstanding", angle));
                end
                else
                begin
                    c = angle_fifo.pop_front();
                    if (angle !== c.angle)
                        report_mismatch($sformatf("opposite %0d adjacent %0d: got %0d, want %0d",
                                                  c.opp, c.adj, angle, c.angle));
                end
            end
            pending <= angle_fifo.size();
        end
        else
        begin
            // clear the tallies while reset is held
            fail_count = 0;
            pending      <= 0;
            vectors_seen <= 0;
            angles_seen  <= 0;
            axis_seen    <= 0;
        end
    end

endmodule

// ===== tb/tb_full_circle_arctangent.sv =====
// Testbench top for the full-circle arctangent: clock, reset, traffic and verdict.
`timescale 1ns / 1ps
module tb_full_circle_arctangent;
    import fac_pkg::*;

    localparam int DW            = DATA_WIDTH_DEF;
    localparam int AW            = ANGLE_WIDTH_DEF;
    localparam int RESET_CYCLES  = 7;
    localparam int ITEM_TARGET   = 500;
    // pipeline is 37 deep; give a few cycles of margin at the end
    localparam int SETTLE_CYCLES = 45;
    // long output hold-off; the pipeline must fill and push back on the input
    localparam int LONG_HOLD     = 200;
    // no transaction on either side for this long means the block is hung
    localparam int IDLE_LIMIT    = 4000;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 vector_valid = 1'b0;
    logic                 vector_stall;
    logic signed [DW-1:0] opposite     = '0;
    logic signed [DW-1:0] adjacent     = '0;
    logic                 angle_valid;
    logic                 angle_stall  = 1'b0;
    logic [AW-1:0]        angle;

    // set once the random traffic starts, so long hold-offs land on it
    logic                 random_phase = 1'b0;

    int fail_count;
    int pending;
    int vectors_seen;
    int angles_seen;
    int axis_seen;
    int idle_cycles   = 0;
    int input_stalls  = 0;
    int long_holds    = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    full_circle_arctangent #(
        .DATA_WIDTH  (DW),
        .ANGLE_WIDTH (AW)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vector_valid (vector_valid),
        .vector_stall (vector_stall),
        .opposite     (opposite),
        .adjacent     (adjacent),
        .angle_valid  (angle_valid),
        .angle_stall  (angle_stall),
        .angle        (angle)
    );

    fac_angle_check #(
        .DATA_WIDTH  (DW),
        .ANGLE_WIDTH (AW)
    ) angle_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .vector_valid (vector_valid),
        .vector_stall (vector_stall),
        .opposite     (opposite),
        .adjacent     (adjacent),
        .angle_valid  (angle_valid),
        .angle_stall  (angle_stall),
        .angle        (angle),
        .fail_count   (fail_count),
        .pending      (pending),
        .vectors_seen (vectors_seen),
        .angles_seen  (angles_seen),
        .axis_seen    (axis_seen)
    );

    // Offer one vector and hold it until the block takes it. Valid stays high
    // on return, so back-to-back calls make a burst with no bubble.
    task automatic send_vector(input logic signed [DW-1:0] opp, input logic signed [DW-1:0] adj);
        vector_valid <= 1'b1;
        opposite     <= opp;
        adjacent     <= adj;
        do
            @(posedge clk);
        while (vector_stall);
    endtask

    // Drop valid for a gap; scramble the payload while nothing is offered.
    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            vector_valid <= 1'b0;
            opposite     <= DW'($urandom);
            adjacent     <= DW'($urandom);
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every angle has come back.
    task automatic drain_angles();
        vector_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Pick a random vector: mostly full-range, with weight on the axes,
    // the extremes, tiny magnitudes and vectors hugging an axis.
    task automatic pick_vector(output logic signed [DW-1:0] opp, output logic signed [DW-1:0] adj);
        int kind;
        int a;
        int b;
        kind = $urandom_range(0, 99);
        a    = $urandom;
        b    = $urandom;
        if (kind < 55)
        begin
            opp = DW'(a);
            adj = DW'(b);
        end
        else if (kind < 70)
        begin
            opp = DW'(int'($urandom_range(0, 32)) - 16);
            adj = DW'(int'($urandom_range(0, 32)) - 16);
        end
        else if (kind < 80)
        begin
            case ($urandom_range(0, 4))
                0:       begin opp = '0;     adj = DW'(b); end
                1:       begin opp = DW'(a); adj = '0;     end
                2:       begin opp = '0;     adj = '0;     end
                3:       begin opp = '0;     adj = {1'b1, {(DW-1){1'b0}}}; end
                default: begin opp = {1'b1, {(DW-1){1'b0}}}; adj = '0; end
            endcase
        end
        else if (kind < 90)
        begin
            case ($urandom_range(0, 3))
                0:       opp = {1'b1, {(DW-1){1'b0}}};
                1:       opp = {1'b0, {(DW-1){1'b1}}};
                2:       opp = '1;
                default: opp = DW'(1);
            endcase
            case ($urandom_range(0, 3))
                0:       adj = {1'b1, {(DW-1){1'b0}}};
                1:       adj = {1'b0, {(DW-1){1'b1}}};
                2:       adj = '1;
                default: adj = DW'(1);
            endcase
        end
        else
        begin
            // one component of magnitude two or less: angles on or right next to an axis
            if ($urandom_range(0, 1))
            begin
                opp = DW'(int'($urandom_range(0, 3)) - 2);
                adj = DW'(b);
            end
            else
            begin
                opp = DW'(a);
                adj = DW'(int'($urandom_range(0, 3)) - 2);
            end
        end
    endtask

    // Stimulus: reset, directed corners, a drain, then random bursts with gaps.
    initial
    begin : stimulus
        logic signed [DW-1:0] opp;
        logic signed [DW-1:0] adj;
        int                   sent;
        int                   burst;
        int                   k;
        bit                   drained;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Axis cases, including the origin which must give a half turn.
        send_vector(16'sd0, 16'sd0);
        send_vector(16'sd0, 16'sd1);
        send_vector(16'sd0, -16'sd1);
        send_vector(16'sd0, 16'sd32767);
        send_vector(16'sd0, -16'sd32768);
        send_vector(16'sd1, 16'sd0);
        send_vector(-16'sd1, 16'sd0);
        send_vector(16'sd32767, 16'sd0);
        send_vector(-16'sd32768, 16'sd0);
        // Most negative values and the diagonals at full scale.
        send_vector(16'sd32767, 16'sd32767);
        send_vector(-16'sd32768, -16'sd32768);
        send_vector(16'sd32767, -16'sd32768);
        send_vector(-16'sd32768, 16'sd32767);
        send_vector(-16'sd32768, -16'sd1);
        send_vector(16'sd32767, 16'sd1);
        // Just below a full turn: the first rounds up and wraps to zero.
        send_vector(-16'sd1, 16'sd32767);
        send_vector(-16'sd1, 16'sd20000);
        // Just either side of a half turn.
        send_vector(-16'sd1, -16'sd32768);
        send_vector(16'sd1, -16'sd32768);
        // Unit diagonals in every quadrant, plus one plain vector.
        send_vector(16'sd1, 16'sd1);
        send_vector(16'sd1, -16'sd1);
        send_vector(-16'sd1, -16'sd1);
        send_vector(-16'sd1, 16'sd1);
        send_vector(16'sd12345, -16'sd23456);

        drain_angles();
        random_phase <= 1'b1;

        sent    = 0;
        drained = 1'b0;
        while (sent < ITEM_TARGET)
        begin
            burst = $urandom_range(1, 32);
            for (k = 0; k < burst && sent < ITEM_TARGET; k++)
            begin
                pick_vector(opp, adj);
                send_vector(opp, adj);
                sent++;
            end
            if (!drained && sent >= ITEM_TARGET / 2)
            begin
                // pause mid-run until the pipeline is empty
                drain_angles();
                drained = 1'b1;
            end
            else if ($urandom_range(0, 9) >= 3)
            begin
                pause_sender($urandom_range(1, 12));
            end
        end

        vector_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d vectors (%0d on an axis) and %0d angles: corners, wrap near a turn,",
                 vectors_seen, axis_seen, angles_seen);
        $display("random bursts, %0d input back-pressure cycles, %0d long output hold-offs.",
                 input_stalls, long_holds);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Receiver: stall in segments of varying character. Every eighth segment
    // in the random part is a long hold-off so the pipeline backs up fully.
    initial
    begin : receiver
        int seg;
        int len;
        int mode;
        int k;
        seg = 0;
        forever
        begin
            seg++;
            if (random_phase && seg % 8 == 4)
            begin
                angle_stall <= 1'b1;
                long_holds++;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(10, 60);
                for (k = 0; k < len; k++)
                begin
                    case (mode)
                        0:       angle_stall <= 1'b0;
                        1:       angle_stall <= ($urandom_range(0, 3) == 0);
                        2:       angle_stall <= 1'($urandom_range(0, 1));
                        default: angle_stall <= (k % 4 != 3);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel, and input stalls.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((vector_valid && !vector_stall) || (angle_valid && !angle_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (vector_valid && vector_stall)
                input_stalls <= input_stalls + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles, %0d angles outstanding",
                         idle_cycles, pending);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
